// ===== rtl/roulette_wheel_selector_defines.svh =====
// Assertion macros shared by the roulette wheel selector RTL.
`ifndef ROULETTE_WHEEL_SELECTOR_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Checks an implication or sequence property on every clock edge out of reset.
`define RWS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("roulette wheel selector assertion failed");

// Checks that a condition never holds on any clock edge out of reset.
`define RWS_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("roulette wheel selector forbidden condition seen");

`else

`define RWS_ASSERT(lbl, clk, rst_n, prop)
`define RWS_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/rws_pkg.sv =====
// Shared constants and types of the roulette wheel selector.
`timescale 1ns / 1ps
`default_nettype none

package rws_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int FIT_SCALE   = 10000;

    localparam int COST_W   = 16;
    localparam int DENOM_W  = COST_W + 1;
    localparam int FIT_W    = $clog2(FIT_SCALE + 1);
    localparam int IDX_W    = $clog2(MAX_ENTRIES);
    localparam int COUNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int TOTAL_W  = $clog2(MAX_ENTRIES * FIT_SCALE + 1);
    localparam int RAND_W   = 32;
    localparam int DVD_W    = RAND_W;
    localparam int DIVR_W   = (TOTAL_W > DENOM_W) ? TOTAL_W : DENOM_W;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_SELECT = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Search token that travels down the cell chain.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [TOTAL_W-1:0] target;
    } token_t;

    // Broadcast write of one fitness value into the cell chain.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [FIT_W-1:0] data;
    } fit_wr_t;

endpackage

`default_nettype wire

// ===== rtl/rws_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rws_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [rws_pkg::DVD_W-1:0]   dividend,
    input  wire logic [rws_pkg::DIVR_W-1:0]  divisor,
    output logic                             done,
    output logic [rws_pkg::DVD_W-1:0]        quotient,
    output logic [rws_pkg::DIVR_W-1:0]       remainder
);

    logic                           run_reg;
    logic                           run_next;
    logic                           done_reg;
    logic                           done_next;
    logic [rws_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [rws_pkg::DIV_CNT_W-1:0]  cnt_next;
    logic [rws_pkg::DVD_W-1:0]      dvd_reg;
    logic [rws_pkg::DVD_W-1:0]      dvd_next;
    logic [rws_pkg::DIVR_W-1:0]     rem_reg;
    logic [rws_pkg::DIVR_W-1:0]     rem_next;
    logic [rws_pkg::DIVR_W-1:0]     dvs_reg;
    logic [rws_pkg::DIVR_W-1:0]     dvs_next;
    logic [rws_pkg::DIVR_W:0]       trial;
    logic                           fits;

    // The partial remainder shifted left by one with the next dividend bit.
    assign trial = {rem_reg, dvd_reg[rws_pkg::DVD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dvd_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            // Quotient bits shift in at the bottom as dividend bits leave the top.
            dvd_next = {dvd_reg[rws_pkg::DVD_W-2:0], fits};
            if (fits)
            begin
                rem_next = rws_pkg::DIVR_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[rws_pkg::DIVR_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rws_pkg::DIV_CNT_W'(rws_pkg::DVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/rws_cell.sv =====
// One cell of the selection chain: holds one fitness value and passes the search token on.
`timescale 1ns / 1ps
`default_nettype none

module rws_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [rws_pkg::IDX_W-1:0]  cell_idx,
    input  wire rws_pkg::fit_wr_t           fit_wr,
    input  wire rws_pkg::token_t            tok_in,
    output rws_pkg::token_t                 tok_out
);

    logic [rws_pkg::FIT_W-1:0] fit_reg;
    rws_pkg::token_t           tok_reg;
    rws_pkg::token_t           tok_next;

    always_ff @(posedge clk)
    begin
        if (fit_wr.en && (fit_wr.idx == cell_idx))
        begin
            fit_reg <= fit_wr.data;
        end
    end

    // A token that is still searching either consumes this cell's share of the
    // wheel or stops here; once found it passes through unchanged.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found)
        begin
            if (tok_in.target > rws_pkg::TOTAL_W'(fit_reg))
            begin
                tok_next.target = tok_in.target - rws_pkg::TOTAL_W'(fit_reg);
            end
            else
            begin
                tok_next.found = 1'b1;
                tok_next.idx   = cell_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/roulette_wheel_selector.sv =====
// Top level of the roulette wheel selector for fitness proportionate selection.
`timescale 1ns / 1ps
`default_nettype none
`include "roulette_wheel_selector_defines.svh"

// Input transactions carry action, cost and random_word; a transaction is taken
// when in_valid is high and in_stall is low. A clear empties the pool. A load
// runs the shared 32-step divider to form 10000 / (cost - best + 1) and writes it
// into the next cell. A select runs the same divider for random_word mod total,
// then sends the target down the chain of 64 cells, one cell per cycle; an empty
// pool gives index zero with status set and runs no division. Loads and clears
// give no result. The divider and the chain walk set the rate; one transaction
// is worked on at a time, and in_stall is high while busy. A result sits in an
// output register; while out_stall is high it holds, and a new input transaction
// may still be taken, with a finished select waiting for the register to free.
// best_cost is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this. Reset
// empties the pool and clears best_cost; stored fitness values need no clearing
// since only loaded entries are ever reached.

module roulette_wheel_selector (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [rws_pkg::COST_W-1:0]   cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   action,
    input  wire logic [rws_pkg::COST_W-1:0]   cost,
    input  wire logic [rws_pkg::RAND_W-1:0]   random_word,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [rws_pkg::IDX_W-1:0]         chosen_index,
    output logic                              status
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [rws_pkg::COST_W-1:0]     best_cost_reg;
    logic [rws_pkg::COUNT_W-1:0]    entry_count_reg;
    logic [rws_pkg::COUNT_W-1:0]    entry_count_next;
    logic [rws_pkg::TOTAL_W-1:0]    fitness_total_reg;
    logic [rws_pkg::TOTAL_W-1:0]    fitness_total_next;
    logic                           op_sel_reg;
    logic                           op_sel_next;
    rws_pkg::token_t                head_tok_reg;
    rws_pkg::token_t                head_tok_next;
    logic [rws_pkg::IDX_W-1:0]      res_idx_reg;
    logic [rws_pkg::IDX_W-1:0]      res_idx_next;
    logic                           res_status_reg;
    logic                           res_status_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [rws_pkg::IDX_W-1:0]      out_idx_reg;
    logic [rws_pkg::IDX_W-1:0]      out_idx_next;
    logic                           out_status_reg;
    logic                           out_status_next;

    logic                           in_accept;
    logic                           out_fire;
    logic                           div_start;
    logic [rws_pkg::DVD_W-1:0]      div_dividend;
    logic [rws_pkg::DIVR_W-1:0]     div_divisor;
    logic                           div_done;
    logic [rws_pkg::DVD_W-1:0]      div_quot;
    logic [rws_pkg::DIVR_W-1:0]     div_rem;
    logic [rws_pkg::DENOM_W-1:0]    denom;
    logic [rws_pkg::FIT_W-1:0]      new_fit;
    rws_pkg::fit_wr_t               fit_wr;
    rws_pkg::token_t                tok [0:rws_pkg::MAX_ENTRIES];

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_fire  = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);

    // A cost below the best cost clamps the denominator to one.
    always_comb
    begin
        if (cost < best_cost_reg)
        begin
            denom = rws_pkg::DENOM_W'(1);
        end
        else
        begin
            denom = rws_pkg::DENOM_W'({1'b0, cost} - {1'b0, best_cost_reg} + 1'b1);
        end
    end

    assign new_fit = div_quot[rws_pkg::FIT_W-1:0];

    always_comb
    begin
        state_next         = state_reg;
        entry_count_next   = entry_count_reg;
        fitness_total_next = fitness_total_reg;
        op_sel_next        = op_sel_reg;
        head_tok_next      = '0;
        res_idx_next       = res_idx_reg;
        res_status_next    = res_status_reg;
        div_start          = 1'b0;
        div_dividend       = rws_pkg::DVD_W'(rws_pkg::FIT_SCALE);
        div_divisor        = rws_pkg::DIVR_W'(denom);
        fit_wr.en          = 1'b0;
        fit_wr.idx         = entry_count_reg[rws_pkg::IDX_W-1:0];
        fit_wr.data        = new_fit;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (action)
                        rws_pkg::ACT_LOAD:
                        begin
                            if (entry_count_reg < rws_pkg::COUNT_W'(rws_pkg::MAX_ENTRIES))
                            begin
                                div_start   = 1'b1;
                                op_sel_next = 1'b0;
                                state_next  = ST_DIV;
                            end
                        end
                        rws_pkg::ACT_SELECT:
                        begin
                            if (fitness_total_reg == '0)
                            begin
                                res_idx_next    = '0;
                                res_status_next = 1'b1;
                                state_next      = ST_RESULT;
                            end
                            else
                            begin
                                div_start    = 1'b1;
                                div_dividend = random_word;
                                div_divisor  = rws_pkg::DIVR_W'(fitness_total_reg);
                                op_sel_next  = 1'b1;
                                state_next   = ST_DIV;
                            end
                        end
                        rws_pkg::ACT_CLEAR:
                        begin
                            entry_count_next   = '0;
                            fitness_total_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (op_sel_reg)
                    begin
                        head_tok_next.valid  = 1'b1;
                        head_tok_next.found  = 1'b0;
                        head_tok_next.idx    = '0;
                        head_tok_next.target = div_rem[rws_pkg::TOTAL_W-1:0] + 1'b1;
                        state_next           = ST_WALK;
                    end
                    else
                    begin
                        fit_wr.en          = 1'b1;
                        entry_count_next   = entry_count_reg + 1'b1;
                        fitness_total_next = fitness_total_reg
                                           + rws_pkg::TOTAL_W'(new_fit);
                        state_next         = ST_IDLE;
                    end
                end
            end
            ST_WALK:
            begin
                // The target never exceeds the total, so the token is always
                // found within the loaded entries.
                if (tok[rws_pkg::MAX_ENTRIES].valid)
                begin
                    res_idx_next    = tok[rws_pkg::MAX_ENTRIES].found
                                    ? tok[rws_pkg::MAX_ENTRIES].idx : '0;
                    res_status_next = !tok[rws_pkg::MAX_ENTRIES].found;
                    state_next      = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;
        if (out_fire)
        begin
            out_valid_next  = 1'b1;
            out_idx_next    = res_idx_reg;
            out_status_next = res_status_reg;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            best_cost_reg     <= '0;
            entry_count_reg   <= '0;
            fitness_total_reg <= '0;
            op_sel_reg        <= 1'b0;
            head_tok_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            entry_count_reg   <= entry_count_next;
            fitness_total_reg <= fitness_total_next;
            op_sel_reg        <= op_sel_next;
            head_tok_reg      <= head_tok_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_wr_en)
            begin
                best_cost_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        out_idx_reg    <= out_idx_next;
        out_status_reg <= out_status_next;
    end

    rws_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign tok[0] = head_tok_reg;

    for (genvar g = 0; g < rws_pkg::MAX_ENTRIES; g++)
    begin : g_cell
        rws_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (rws_pkg::IDX_W'(g)),
            .fit_wr   (fit_wr),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
    end

    assign out_valid    = out_valid_reg;
    assign chosen_index = out_idx_reg;
    assign status       = out_status_reg;

    `RWS_NEVER(a_count_bound, clk, rst_n,
        entry_count_reg > rws_pkg::COUNT_W'(rws_pkg::MAX_ENTRIES))
    `RWS_ASSERT(a_empty_total, clk, rst_n,
        (entry_count_reg == '0) |-> (fitness_total_reg == '0))
    `RWS_ASSERT(a_div_in_div, clk, rst_n, div_done |-> (state_reg == ST_DIV))
    `RWS_ASSERT(a_token_found, clk, rst_n,
        tok[rws_pkg::MAX_ENTRIES].valid |-> tok[rws_pkg::MAX_ENTRIES].found)
    `RWS_ASSERT(a_result_from_walk, clk, rst_n,
        ($rose(out_valid_reg) && !$past(fitness_total_reg == '0)) |-> !out_status_reg)

endmodule

`default_nettype wire
